>>> rtl/lkv_cache_pkg.sv
// ----------------------------------------------------------------------------
// lkv_cache_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_cache_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_WIDTH  = 32;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int IN_KEY_W   = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_AGE    = 5'b01000,
    ST_WRITE  = 5'b10000
  } lkv_state_t;

  typedef struct packed {
    logic key_we;
    logic val_we;
    logic rank_we;
    logic set_valid;
  } lkv_wr_ctl_t;

endpackage

>>> rtl/lkv_cache_store.sv
// ----------------------------------------------------------------------------
// lkv_cache_store
// Entry storage: key, value and rank memories with registered read, plus
// per-entry valid flops cleared by reset.
// ----------------------------------------------------------------------------
module lkv_cache_store
  import lkv_cache_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int AW = $clog2(CAPACITY),
  localparam int RW = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic                  rd_valid,
  output logic [KEY_WIDTH-1:0]  rd_key,
  output logic [DATA_WIDTH-1:0] rd_value,
  output logic [RW-1:0]         rd_rank,
  input  lkv_wr_ctl_t           wr_ctl,
  input  logic [AW-1:0]         wr_addr,
  input  logic [KEY_WIDTH-1:0]  wr_key,
  input  logic [DATA_WIDTH-1:0] wr_value,
  input  logic [RW-1:0]         wr_rank
);

  logic [KEY_WIDTH-1:0]  key_mem  [CAPACITY];
  logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic [RW-1:0]         rank_mem [CAPACITY];
  logic [CAPACITY-1:0]   valid_r;
  logic                  rd_valid_r;
  logic [KEY_WIDTH-1:0]  rd_key_r;
  logic [DATA_WIDTH-1:0] rd_value_r;
  logic [RW-1:0]         rd_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.set_valid) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_ctl.val_we) begin
      val_mem[wr_addr] <= wr_value;
    end
    if (wr_ctl.rank_we) begin
      rank_mem[wr_addr] <= wr_rank;
    end
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
      rd_key_r   <= key_mem[rd_addr];
      rd_value_r <= val_mem[rd_addr];
      rd_rank_r  <= rank_mem[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_key_r;
  assign rd_value = rd_value_r;
  assign rd_rank  = rd_rank_r;

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with LRU replacement. A sequencer sweeps
// the entry store one entry per cycle through a single key/rank compare unit.
// ----------------------------------------------------------------------------
// Sequence: a get miss, or a put with no free and no LRU entry, strobes from
// the decide state after the scan sweep; every other request also takes an
// ageing sweep over the rank memory, one entry per cycle, then a write state.
// busy is high from acceptance until the strobe; the next start is taken then.
// Synchronous reset invalidates all entries at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkv_cache_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [IN_KEY_W-1:0]   in_lookup_key,
  input  logic [IN_DATA_W-1:0]  in_write_data,
  output logic                  out_strobe,
  output logic                  out_hit,
  output logic [OUT_DATA_W-1:0] out_read_data,
  output logic                  out_evicted
);

  localparam int AW = $clog2(CAPACITY);
  localparam int RW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  lkv_state_t            state_r, state_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  logic                  is_get_r, is_get_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  match_r, match_nxt;
  logic [AW-1:0]         found_r, found_nxt;
  logic [RW-1:0]         frank_r, frank_nxt;
  logic                  have_free_r, have_free_nxt;
  logic [AW-1:0]         free_r, free_nxt;
  logic                  have_lru_r, have_lru_nxt;
  logic [AW-1:0]         lru_r, lru_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [RW:0]           rlim_r, rlim_nxt;
  logic                  evict_r, evict_nxt;
  logic [DATA_WIDTH-1:0] rdata_r, rdata_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                  out_evicted_r, out_evicted_nxt;

  logic                  rd_en;
  logic                  rd_valid;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [DATA_WIDTH-1:0] rd_value;
  logic [RW-1:0]         rd_rank;
  lkv_wr_ctl_t           wr_ctl;
  logic [AW-1:0]         wr_addr;
  logic [RW-1:0]         wr_rank;
  logic                  sweep_end;
  logic                  key_eq;
  logic                  rank_lt;
  logic                  rank_lru;

  lkv_cache_store #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (idx_r[AW-1:0]),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_rank  (rd_rank),
    .wr_ctl   (wr_ctl),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_value (data_r),
    .wr_rank  (wr_rank)
  );

  // shared compare unit
  assign key_eq   = rd_valid && (rd_key == key_r);
  assign rank_lt  = rd_valid && ({1'b0, rd_rank} < rlim_r);
  assign rank_lru = rd_valid && (rd_rank == RW'(CAPACITY - 1));

  assign sweep_end = (idx_r == CW'(CAPACITY)) && pend_r;
  assign rd_en     = ((state_r == ST_SCAN) || (state_r == ST_AGE)) &&
                     (idx_r != CW'(CAPACITY));
  assign wr_addr   = (state_r == ST_WRITE) ? slot_r : pidx_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pend_nxt        = rd_en;
    pidx_nxt        = idx_r[AW-1:0];
    is_get_nxt      = is_get_r;
    key_nxt         = key_r;
    data_nxt        = data_r;
    match_nxt       = match_r;
    found_nxt       = found_r;
    frank_nxt       = frank_r;
    have_free_nxt   = have_free_r;
    free_nxt        = free_r;
    have_lru_nxt    = have_lru_r;
    lru_nxt         = lru_r;
    slot_nxt        = slot_r;
    rlim_nxt        = rlim_r;
    evict_nxt       = evict_r;
    rdata_nxt       = rdata_r;
    out_strobe_nxt  = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_data_nxt    = out_data_r;
    out_evicted_nxt = out_evicted_r;
    wr_ctl          = '0;
    wr_rank         = '0;
    if (rd_en) begin
      idx_nxt = idx_r + CW'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt     = ST_SCAN;
          idx_nxt       = '0;
          is_get_nxt    = (in_req_type == REQ_GET);
          key_nxt       = KEY_WIDTH'(in_lookup_key);
          data_nxt      = DATA_WIDTH'(in_write_data);
          match_nxt     = 1'b0;
          have_free_nxt = 1'b0;
          have_lru_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (key_eq && !match_r) begin
            match_nxt = 1'b1;
            found_nxt = pidx_r;
            frank_nxt = rd_rank;
          end
          if (!rd_valid && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = pidx_r;
          end
          if (rank_lru && !have_lru_r) begin
            have_lru_nxt = 1'b1;
            lru_nxt      = pidx_r;
          end
        end
        if (sweep_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        idx_nxt   = '0;
        rdata_nxt = '0;
        evict_nxt = 1'b0;
        priority if (match_r) begin
          slot_nxt  = found_r;
          rlim_nxt  = {1'b0, frank_r};
          state_nxt = ST_AGE;
        end else if (is_get_r) begin
          state_nxt       = ST_IDLE;
          out_strobe_nxt  = 1'b1;
          out_hit_nxt     = 1'b0;
          out_data_nxt    = '0;
          out_evicted_nxt = 1'b0;
        end else if (have_free_r) begin
          slot_nxt  = free_r;
          rlim_nxt  = (RW + 1)'(CAPACITY);
          state_nxt = ST_AGE;
        end else if (have_lru_r) begin
          slot_nxt  = lru_r;
          rlim_nxt  = (RW + 1)'(CAPACITY - 1);
          evict_nxt = 1'b1;
          state_nxt = ST_AGE;
        end else begin
          state_nxt       = ST_IDLE;
          out_strobe_nxt  = 1'b1;
          out_hit_nxt     = 1'b0;
          out_data_nxt    = '0;
          out_evicted_nxt = 1'b0;
        end
      end
      ST_AGE: begin
        if (pend_r) begin
          if (pidx_r == slot_r) begin
            if (is_get_r) begin
              rdata_nxt = rd_value;
            end
          end else if (rank_lt) begin
            wr_ctl.rank_we = 1'b1;
            wr_rank        = rd_rank + RW'(1);
          end
        end
        if (sweep_end) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr_ctl.rank_we   = 1'b1;
        wr_ctl.set_valid = 1'b1;
        wr_ctl.val_we    = !is_get_r;
        wr_ctl.key_we    = !is_get_r && !match_r;
        wr_rank          = '0;
        state_nxt        = ST_IDLE;
        out_strobe_nxt   = 1'b1;
        out_hit_nxt      = match_r;
        out_data_nxt     = rdata_r;
        out_evicted_nxt  = evict_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r        <= pidx_nxt;
    is_get_r      <= is_get_nxt;
    key_r         <= key_nxt;
    data_r        <= data_nxt;
    match_r       <= match_nxt;
    found_r       <= found_nxt;
    frank_r       <= frank_nxt;
    have_free_r   <= have_free_nxt;
    free_r        <= free_nxt;
    have_lru_r    <= have_lru_nxt;
    lru_r         <= lru_nxt;
    slot_r        <= slot_nxt;
    rlim_r        <= rlim_nxt;
    evict_r       <= evict_nxt;
    rdata_r       <= rdata_nxt;
    out_hit_r     <= out_hit_nxt;
    out_data_r    <= out_data_nxt;
    out_evicted_r <= out_evicted_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_hit       = out_hit_r;
  assign out_read_data = OUT_DATA_W'(out_data_r);
  assign out_evicted   = out_evicted_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_WRITE) || ($past(state_r) == ST_DECIDE))
    else $error("result beat without finishing state");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_SCAN)
    else $error("accepted request did not start scan");

  a_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_evicted |-> !out_hit && (out_read_data == '0))
    else $error("eviction beat with hit or data");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_hit |-> out_read_data == '0)
    else $error("miss beat with non-zero data");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CW'(CAPACITY))
    else $error("sweep index out of range");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache. A short directed table covers
// reset state, the extreme keys and data, put and get hits and misses, and a
// fill up to capacity followed by an eviction of the least recent entry. A
// random phase follows, using key pools of varying size so that hits, refills
// and thrashing evictions all occur. Each beat is checked on out_strobe against
// a shadow cache with its own recency ranks, or against its typed table row.
// ----------------------------------------------------------------------------
module tb
  import lkv_cache_pkg::*;
();

  localparam int CAP       = DEF_CAPACITY;
  localparam int N_DIRECT  = 25;
  localparam int N_RANDOM  = 1250;
  localparam int BLOCK_LEN = 250;
  localparam int POOL_MAX  = 40;

  typedef struct packed {
    logic                  hit;
    logic [OUT_DATA_W-1:0] read_data;
    logic                  evicted;
  } access_result_t;

  typedef struct packed {
    logic                 req;
    logic [IN_KEY_W-1:0]  key;
    logic [IN_DATA_W-1:0] data;
    logic                 typed;
    access_result_t       result;
  } direct_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  logic [IN_KEY_W-1:0]   in_lookup_key;
  logic [IN_DATA_W-1:0]  in_write_data;
  logic                  out_strobe;
  logic                  out_hit;
  logic [OUT_DATA_W-1:0] out_read_data;
  logic                  out_evicted;

  lru_key_value_cache dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_lookup_key (in_lookup_key),
    .in_write_data (in_write_data),
    .out_strobe    (out_strobe),
    .out_hit       (out_hit),
    .out_read_data (out_read_data),
    .out_evicted   (out_evicted)
  );

  // shadow cache
  logic                 shadow_valid [CAP];
  logic [IN_KEY_W-1:0]  shadow_key   [CAP];
  logic [IN_DATA_W-1:0] shadow_value [CAP];
  int                   shadow_rank  [CAP];
  int                   shadow_free;

  access_result_t pending_results [$];
  int             mismatches;

  logic [IN_KEY_W-1:0] key_pool [POOL_MAX];
  int                  pool_len;
  bit                  no_idle;

  direct_row_t direct_rows [N_DIRECT] = '{
    '{REQ_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0}},
    '{REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0}},
    '{REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0}},
    '{REQ_PUT, 32'h0000_0001, 32'hA5A5_0001, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0002, 32'h5A5A_0002, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0003, 32'hA5A5_0003, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0004, 32'h5A5A_0004, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0005, 32'hA5A5_0005, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0006, 32'h5A5A_0006, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0007, 32'hA5A5_0007, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0008, 32'h5A5A_0008, 1'b0, '0},
    '{REQ_PUT, 32'h8000_0009, 32'hA5A5_0009, 1'b0, '0},
    '{REQ_PUT, 32'h8000_000A, 32'h5A5A_000A, 1'b0, '0},
    '{REQ_PUT, 32'h8000_000B, 32'hA5A5_000B, 1'b0, '0},
    '{REQ_PUT, 32'h8000_000C, 32'h5A5A_000C, 1'b0, '0},
    '{REQ_PUT, 32'h8000_000D, 32'hA5A5_000D, 1'b0, '0},
    '{REQ_PUT, 32'h8000_000E, 32'h5A5A_000E, 1'b0, '0},
    '{REQ_PUT, 32'h0000_0064, 32'hC3C3_3C3C, 1'b1, '{1'b0, 32'h0, 1'b1}},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{REQ_GET, 32'h0000_0064, 32'h0000_0000, 1'b0, '0}
  };

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic access_result_t predict_access(logic req, logic [IN_KEY_W-1:0] key,
                                                    logic [IN_DATA_W-1:0] data);
    access_result_t r;
    int found;
    int slot;
    int age_from;
    r        = '0;
    found    = -1;
    slot     = -1;
    age_from = CAP;
    for (int i = 0; i < CAP; i++)
      if (shadow_valid[i] && shadow_key[i] == key && found < 0) found = i;
    if (found >= 0) begin
      r.hit    = 1'b1;
      slot     = found;
      age_from = shadow_rank[found];
      if (req == REQ_GET) r.read_data = shadow_value[found];
      else shadow_value[found] = data;
    end else if (req == REQ_PUT) begin
      if (shadow_free > 0) begin
        for (int i = 0; i < CAP; i++)
          if (!shadow_valid[i] && slot < 0) slot = i;
        age_from = CAP;
      end else begin
        for (int i = 0; i < CAP; i++)
          if (shadow_valid[i] && shadow_rank[i] == CAP - 1 && slot < 0) slot = i;
        age_from = CAP - 1;
      end
      if (slot >= 0) begin
        if (!shadow_valid[slot]) begin
          shadow_valid[slot] = 1'b1;
          shadow_free--;
        end else begin
          r.evicted = 1'b1;
        end
        shadow_key[slot]   = key;
        shadow_value[slot] = data;
      end
    end
    if (slot >= 0) begin
      for (int i = 0; i < CAP; i++)
        if (i != slot && shadow_valid[i] && shadow_rank[i] < age_from) shadow_rank[i]++;
      shadow_rank[slot] = 0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 40) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 40);
    return $urandom_range(41, 100);
  endfunction

  // offer one beat, hold it until taken, then queue its expectation
  task automatic send_beat(int gap, logic req, logic [IN_KEY_W-1:0] key,
                           logic [IN_DATA_W-1:0] data, bit use_typed,
                           access_result_t typed);
    access_result_t predicted;
    int             idle_cycles;
    if (gap > 0) begin
      start       <= 1'b0;
      idle_cycles = 0;
      // count only cycles in which the block could have taken a beat
      while (idle_cycles < gap) begin
        @(posedge clk);
        if (busy === 1'b0) idle_cycles++;
      end
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_lookup_key <= key;
    in_write_data <= data;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_access(req, key, data);
    pending_results = {pending_results, (use_typed ? typed : predicted)};
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected result hit=%0b rd=%h ev=%0b",
                   out_hit, out_read_data, out_evicted);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit || out_read_data !== want.read_data ||
            out_evicted !== want.evicted) begin
          if (mismatches < 10)
            $display("tb: mismatch exp hit=%0b rd=%h ev=%0b got hit=%0b rd=%h ev=%0b",
                     want.hit, want.read_data, want.evicted,
                     out_hit, out_read_data, out_evicted);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic                 req;
    logic [IN_KEY_W-1:0]  key;
    logic [IN_DATA_W-1:0] data;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_PUT;
    in_lookup_key = '0;
    in_write_data = '0;
    mismatches    = 0;
    no_idle       = 1'b0;
    pool_len      = 1;
    for (int i = 0; i < CAP; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_rank[i]  = 0;
    end
    shadow_free = CAP;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (direct_rows[i])
      send_beat(pick_gap(), direct_rows[i].req, direct_rows[i].key, direct_rows[i].data,
                direct_rows[i].typed, direct_rows[i].result);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % BLOCK_LEN == 0) begin
        // small pools mostly hit, large ones thrash the replacement
        pool_len = $urandom_range(4, POOL_MAX);
        no_idle  = ($urandom_range(0, 3) == 0);
        foreach (key_pool[k]) key_pool[k] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      req  = $urandom_range(0, 1) ? REQ_GET : REQ_PUT;
      key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_len - 1)]
                                        : $urandom();
      data = $urandom();
      send_beat(pick_gap(), req, key, data, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * CAP + 8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb: errors");
    $finish;
  end

endmodule
